/* hw/rtl/bounded_min_heap_macros.svh */
// Assertion macros for the bounded min-heap RTL.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef BOUNDED_MIN_HEAP_MACROS_SVH
`define BOUNDED_MIN_HEAP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BMH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bounded_min_heap: assertion failed");

`define BMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_min_heap: assertion failed");

`else

`define BMH_ASSERT(lbl, clk, rst_n, prop)

`define BMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/bmh_pkg.sv */
// Types, constants and the key compare for the bounded min-heap.
// No dependencies; imported by bounded_min_heap.
`default_nettype none

package bmh_pkg;

    localparam int KEY_W       = 32;
    localparam int CAP_W       = 5;
    localparam int CNT_OUT_W   = 5;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;
    localparam int M_PAD_W     = M_TDATA_W - KEY_W - CNT_OUT_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } t_bmh_cmd;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RD_LAST  = 9'b000000010,
        ST_GOT_LAST = 9'b000000100,
        ST_SD_L     = 9'b000001000,
        ST_SD_R     = 9'b000010000,
        ST_SD_PICK  = 9'b000100000,
        ST_SU       = 9'b001000000,
        ST_SU_CMP   = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } t_bmh_state;

    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bounded_min_heap.sv */
// Bounded min-heap priority queue: sequencer around one heap store RAM.
// Depends on bmh_pkg, bmh_ram and bounded_min_heap_macros.svh.
//
// Input stream: tdata holds the signed 32-bit key, tuser selects insert (0) or pop (1).
// Every accepted item yields exactly one output transfer: tdata carries the removed key
// (zero when none) and the count after the operation, tuser flags a removed key and a
// pop on an empty heap. An insert into a full heap evicts and reports the minimum first.
// The capacity register is written through i_cfg_we/i_cfg_wdata; the user must write it only
// while the block is idle, as the block itself does not enforce this. 0 acts as 1 and values
// above DEPTH act as DEPTH. One item is in work at a time. Each heap level costs a
// read-compare-write step on the single store RAM, in sift-down (ST_SD_L, ST_SD_R,
// ST_SD_PICK) and in sift-up (ST_SU, ST_SU_CMP). A pop on an empty heap goes straight from
// ST_IDLE to ST_FINISH without touching the store. The finished result sits in an output
// register; a new item is taken once the sequencer has handed its result over, so while
// the receiver stalls the output register holds one result, the sequencer may finish one
// more item and wait with it in ST_FINISH, and the input side then stops.
// Reset clears the count and sets the capacity to 16; the store itself is not cleared.
`default_nettype none
`include "bounded_min_heap_macros.svh"

module bounded_min_heap
    import bmh_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CAP_W-1:0]     i_cfg_wdata,     // capacity_limit
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // [31:0] key_value
    input  wire logic [S_TUSER_W-1:0] i_s_axis_tuser,  // [0] cmd
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] out_value, [36:32] count_after
    output logic      [M_TUSER_W-1:0] o_m_axis_tuser   // [0] out_valid, [1] empty_error
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int EW = CW + CAP_W;

    t_bmh_state          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CAP_W-1:0]    r_cap;
    logic [AW-1:0]       r_pos, n_pos;
    logic [KEY_W-1:0]    r_val, n_val;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_top, n_top;
    logic [KEY_W-1:0]    r_lchild, n_lchild;
    logic                r_ins, n_ins;
    logic                r_pop_ok, n_pop_ok;
    logic                r_err, n_err;
    logic                r_oval;
    logic [M_TDATA_W-1:0] r_odata;
    logic [M_TUSER_W-1:0] r_ouser;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_W-1:0]    ram_rdata;

    logic                s_xfer;
    logic                out_load;
    logic                pop_done;
    logic                start_ins;
    logic                heap_full;
    logic [EW-1:0]       cap_x, cnt_x, eff_x;
    logic [IW-1:0]       cnt_i, left_i, right_i;
    logic [CW-1:0]       cnt_m1;
    logic [AW-1:0]       pos_m1, parent;
    logic                pick_right;
    logic [KEY_W-1:0]    pick_val;
    logic [AW-1:0]       pick_idx;
    logic [CW+CNT_OUT_W-1:0] cnt_out_x;

    bmh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == ST_FINISH) && (!r_oval || i_m_axis_tready);

    assign cap_x     = {{CW{1'b0}}, r_cap};
    assign cnt_x     = {{CAP_W{1'b0}}, r_count};
    assign eff_x     = (cap_x == '0) ? EW'(1) : ((cap_x > EW'(DEPTH)) ? EW'(DEPTH) : cap_x);
    assign heap_full = (cnt_x >= eff_x) && (r_count != '0);

    assign cnt_i   = {{(IW-CW){1'b0}}, r_count};
    assign left_i  = {1'b0, r_pos, 1'b1};
    assign right_i = left_i + 1'b1;
    assign cnt_m1  = r_count - 1'b1;
    assign pos_m1  = r_pos - 1'b1;
    assign parent  = pos_m1 >> 1;

    assign pick_right = !key_less(r_lchild, ram_rdata);
    assign pick_val   = pick_right ? ram_rdata : r_lchild;
    assign pick_idx   = pick_right ? right_i[AW-1:0] : left_i[AW-1:0];

    assign cnt_out_x = {{CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_val     = r_val;
        n_key     = r_key;
        n_top     = r_top;
        n_lchild  = r_lchild;
        n_ins     = r_ins;
        n_pop_ok  = r_pop_ok;
        n_err     = r_err;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        ram_raddr = '0;
        pop_done  = 1'b0;
        start_ins = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_key    = i_s_axis_tdata;
                    n_err    = 1'b0;
                    n_pop_ok = 1'b0;
                    n_ins    = 1'b0;
                    n_top    = '0;
                    if (t_bmh_cmd'(i_s_axis_tuser[0]) == CMD_POP) begin
                        if (r_count == '0) begin
                            n_err   = 1'b1;
                            n_state = ST_FINISH;
                        end else begin
                            n_pop_ok = 1'b1;
                            n_state  = ST_RD_LAST;
                        end
                    end else if (heap_full) begin
                        n_pop_ok = 1'b1;
                        n_ins    = 1'b1;
                        n_state  = ST_RD_LAST;
                    end else begin
                        start_ins = 1'b1;
                    end
                end
            end
            ST_RD_LAST: begin
                n_top     = ram_rdata;
                ram_raddr = cnt_m1[AW-1:0];
                n_count   = cnt_m1;
                n_state   = ST_GOT_LAST;
            end
            ST_GOT_LAST: begin
                n_val = ram_rdata;
                n_pos = '0;
                if (r_count == '0) begin
                    pop_done = 1'b1;
                end else begin
                    n_state = ST_SD_L;
                end
            end
            ST_SD_L: begin
                if (left_i < cnt_i) begin
                    ram_raddr = left_i[AW-1:0];
                    n_state   = ST_SD_R;
                end else begin
                    ram_we   = 1'b1;
                    pop_done = 1'b1;
                end
            end
            ST_SD_R: begin
                n_lchild = ram_rdata;
                if (right_i < cnt_i) begin
                    ram_raddr = right_i[AW-1:0];
                    n_state   = ST_SD_PICK;
                end else if (key_less(ram_rdata, r_val)) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_pos     = left_i[AW-1:0];
                    n_state   = ST_SD_L;
                end else begin
                    ram_we   = 1'b1;
                    pop_done = 1'b1;
                end
            end
            ST_SD_PICK: begin
                if (key_less(pick_val, r_val)) begin
                    ram_we    = 1'b1;
                    ram_wdata = pick_val;
                    n_pos     = pick_idx;
                    n_state   = ST_SD_L;
                end else begin
                    ram_we   = 1'b1;
                    pop_done = 1'b1;
                end
            end
            ST_SU: begin
                if (r_pos == '0) begin
                    ram_we  = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    ram_raddr = parent;
                    n_state   = ST_SU_CMP;
                end
            end
            ST_SU_CMP: begin
                ram_we = 1'b1;
                if (key_less(r_val, ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    n_pos     = parent;
                    n_state   = ST_SU;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (pop_done) begin
            if (r_ins) begin
                start_ins = 1'b1;
            end else begin
                n_state = ST_FINISH;
            end
        end

        if (start_ins) begin
            n_pos   = r_count[AW-1:0];
            n_val   = n_key;
            n_count = r_count + 1'b1;
            n_state = ST_SU;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (out_load) begin
                r_oval <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_key    <= n_key;
        r_top    <= n_top;
        r_lchild <= n_lchild;
        r_ins    <= n_ins;
        r_pop_ok <= n_pop_ok;
        r_err    <= n_err;
        if (out_load) begin
            r_odata <= {{M_PAD_W{1'b0}}, cnt_out_x[CNT_OUT_W-1:0],
                        (r_pop_ok ? r_top : {KEY_W{1'b0}})};
            r_ouser <= {r_err, r_pop_ok};
        end
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `BMH_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `BMH_ASSERT(a_flags_excl, i_clk, i_rst_n, o_m_axis_tvalid |-> !(&o_m_axis_tuser))
    `BMH_ASSERT(a_no_write_idle, i_clk, i_rst_n, (r_state == ST_IDLE) |-> !ram_we)
    `BMH_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_xfer, r_state != ST_IDLE)

endmodule

`default_nettype wire

/* hw/rtl/bmh_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
